### sv/assert_macros.svh
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a given clock and active-low reset.
`define BQ_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed: %m");

// Same, on the house clock and reset names.
`define BQ_ASSERT_CLK(name, prop) `BQ_ASSERT(name, clk_i, rst_ni, prop)

`endif

### sv/bqdf1_pkg.sv
// Shared types and constants of the biquad direct-form-I filter.
package bqdf1_pkg;

  // Coefficient bits consumed per multiply-accumulate step.
  localparam int unsigned DIGIT_W = 4;

  localparam int unsigned NUM_REGS  = 7;
  localparam int unsigned REG_IDX_W = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_FF_GAIN_0 = 3'd0,
    REG_FF_GAIN_1 = 3'd1,
    REG_FF_GAIN_2 = 3'd2,
    REG_FB_GAIN_1 = 3'd3,
    REG_FB_GAIN_2 = 3'd4,
    REG_WET_GAIN  = 3'd5,
    REG_DRY_GAIN  = 3'd6
  } reg_idx_e;

  // Control from the sequencer to the digit-serial multiply-accumulate unit.
  typedef struct packed {
    logic clear;  // zero the accumulator
    logic load;   // load coefficient and multiplicand
    logic step;   // consume one coefficient digit
    logic sub;    // subtract the partial product instead of adding it
    logic last;   // current digit is the most significant (signed) one
  } mac_ctrl_t;

endpackage

### sv/bqdf1_if.sv
// Valid/ready stream interfaces for the filter's sample input and result output.
interface bqdf1_in_if #(
  parameter int SAMPLE_WIDTH = 24
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface bqdf1_out_if #(
  parameter int SAMPLE_WIDTH = 24
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;
  logic                           clipped;

  modport source (output valid, output sample_out, output clipped, input ready);
  modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

### sv/bqdf1_mac.sv
// Digit-serial multiply-accumulate unit: one coefficient digit per cycle while step is asserted.
module bqdf1_mac #(
  parameter int COEFF_WIDTH = 32,
  parameter int OPER_WIDTH  = 31,
  parameter int ACC_WIDTH   = 66
) (
  input  logic                          clk_i,
  input  bqdf1_pkg::mac_ctrl_t          ctrl_i,
  input  logic signed [COEFF_WIDTH-1:0] coef_i,
  input  logic signed [OPER_WIDTH-1:0]  oper_i,
  output logic signed [ACC_WIDTH-1:0]   acc_o
);

  localparam int NUM_DIGITS = (COEFF_WIDTH + bqdf1_pkg::DIGIT_W - 1) / bqdf1_pkg::DIGIT_W;
  localparam int COEFF_PAD  = NUM_DIGITS * bqdf1_pkg::DIGIT_W;

  logic        [COEFF_PAD-1:0]             coef_sr_q;
  logic signed [ACC_WIDTH-1:0]             mcand_q;
  logic signed [ACC_WIDTH-1:0]             acc_q;
  logic signed [bqdf1_pkg::DIGIT_W:0]      digit;
  logic signed [ACC_WIDTH+bqdf1_pkg::DIGIT_W:0] prod_full;
  logic signed [ACC_WIDTH-1:0]             partial;

  // Lower digits are unsigned; the top digit carries the coefficient's sign.
  always_comb begin
    if (ctrl_i.last) begin
      digit = {coef_sr_q[bqdf1_pkg::DIGIT_W-1], coef_sr_q[bqdf1_pkg::DIGIT_W-1:0]};
    end else begin
      digit = {1'b0, coef_sr_q[bqdf1_pkg::DIGIT_W-1:0]};
    end
    prod_full = mcand_q * digit;
    partial   = prod_full[ACC_WIDTH-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      coef_sr_q <= COEFF_PAD'(coef_i);
      mcand_q   <= ACC_WIDTH'(oper_i);
    end else if (ctrl_i.step) begin
      coef_sr_q <= coef_sr_q >> bqdf1_pkg::DIGIT_W;
      mcand_q   <= mcand_q <<< bqdf1_pkg::DIGIT_W;
    end
    if (ctrl_i.clear) begin
      acc_q <= '0;
    end else if (ctrl_i.step) begin
      acc_q <= ctrl_i.sub ? (acc_q - partial) : (acc_q + partial);
    end
  end

  assign acc_o = acc_q;

endmodule

### sv/biquad_iir_filter_df1_unit.sv
// One sample is in work at a time: a new input is taken only once the previous
// result has entered the output register. NUM_DIGITS = ceil(COEFF_WIDTH/4), and one
// 4-bit coefficient digit is consumed per cycle by the single shared multiply-accumulate
// unit, one product after another.
// Reset: asynchronous, active low; clears history, result register, and loads the
// coefficient defaults (current-input feedforward and wet gain 1.0, all others zero).
module biquad_iir_filter_df1_unit #(
  parameter int SAMPLE_WIDTH    = 24,
  parameter int COEFF_WIDTH     = 32,
  parameter int COEFF_FRAC_BITS = 28
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bqdf1_pkg::REG_IDX_W-1:0]     cfg_idx_i,
  input  logic [COEFF_WIDTH-1:0]              cfg_wdata_i,
  bqdf1_in_if.sink                            in_i,
  bqdf1_out_if.source                         out_o
);

  // Number of coefficient digits, and so of multiply-accumulate steps per product.
  localparam int NUM_DIGITS = (COEFF_WIDTH + bqdf1_pkg::DIGIT_W - 1) / bqdf1_pkg::DIGIT_W;
  localparam int COEFF_PAD  = NUM_DIGITS * bqdf1_pkg::DIGIT_W;
  localparam int CNT_W      = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

  // The rounded biquad sum B can be wider than a sample: five products of
  // sample by coefficient, less the fraction bits. The multiplicand path is
  // sized for whichever of sample and B is wider.
  localparam int B_RAW      = SAMPLE_WIDTH + COEFF_WIDTH + 3 - COEFF_FRAC_BITS;
  localparam int OPER_W     = (B_RAW > SAMPLE_WIDTH) ? B_RAW : SAMPLE_WIDTH;
  localparam int ACC_W      = OPER_W + COEFF_PAD + 3;

  localparam logic signed [ACC_W-1:0] RND_HALF =
    {{(ACC_W-1){1'b0}}, 1'b1} << (COEFF_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] SAT_MAX =
    ({{(ACC_W-1){1'b0}}, 1'b1} << (SAMPLE_WIDTH - 1)) - 1;
  localparam logic signed [ACC_W-1:0] SAT_MIN = ~SAT_MAX;
  localparam logic signed [COEFF_WIDTH-1:0] COEFF_ONE =
    {{(COEFF_WIDTH-1){1'b0}}, 1'b1} << COEFF_FRAC_BITS;

  // Order in which the seven products are formed. The first five make up the
  // biquad sum, the last two the wet/dry mix.
  typedef enum logic [2:0] {
    P_FF0, P_FF1, P_FF2, P_FB1, P_FB2, P_DRY, P_WET
  } prod_e;

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_MAC, S_RND_B, S_RND_Y
  } state_e;

  // Configuration registers: user writes only while idle; the block does not enforce it.
  logic signed [COEFF_WIDTH-1:0] coef_q [bqdf1_pkg::NUM_REGS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q[bqdf1_pkg::REG_FF_GAIN_0] <= COEFF_ONE;
      coef_q[bqdf1_pkg::REG_FF_GAIN_1] <= '0;
      coef_q[bqdf1_pkg::REG_FF_GAIN_2] <= '0;
      coef_q[bqdf1_pkg::REG_FB_GAIN_1] <= '0;
      coef_q[bqdf1_pkg::REG_FB_GAIN_2] <= '0;
      coef_q[bqdf1_pkg::REG_WET_GAIN]  <= COEFF_ONE;
      coef_q[bqdf1_pkg::REG_DRY_GAIN]  <= '0;
    end else if (cfg_we_i &&
                 (cfg_idx_i < bqdf1_pkg::REG_IDX_W'(bqdf1_pkg::NUM_REGS))) begin
      // Writes beyond the last register are dropped.
      coef_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  state_e                          state_q;
  prod_e                           prod_q;
  logic [CNT_W-1:0]                dig_cnt_q;
  logic signed [SAMPLE_WIDTH-1:0]  x_q;
  logic signed [SAMPLE_WIDTH-1:0]  prev_input_1_q;
  logic signed [SAMPLE_WIDTH-1:0]  prev_input_2_q;
  logic signed [SAMPLE_WIDTH-1:0]  prev_output_1_q;
  logic signed [SAMPLE_WIDTH-1:0]  prev_output_2_q;
  logic signed [OPER_W-1:0]        b_q;
  logic                            out_valid_q;
  logic signed [SAMPLE_WIDTH-1:0]  sample_out_q;
  logic                            clipped_q;

  logic                            in_xfer;
  logic                            out_free;
  logic                            last_digit;
  bqdf1_pkg::mac_ctrl_t            mac_ctrl;
  logic signed [COEFF_WIDTH-1:0]   coef_sel;
  logic signed [OPER_W-1:0]        oper_sel;
  logic signed [ACC_W-1:0]         acc;
  logic signed [ACC_W-1:0]         rnd_sum;
  logic signed [ACC_W-1:0]         rnd_val;
  logic signed [SAMPLE_WIDTH-1:0]  sat_val;
  logic                            sat_clip;

  // The block works on one sample at a time; a finished result waiting in the
  // output register does not hold off the next input transfer.
  assign in_i.ready = (state_q == S_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  assign last_digit = (dig_cnt_q == CNT_W'(NUM_DIGITS - 1));

  // Coefficient and operand for the product in progress. Feedback terms use
  // the stored, already saturated, outputs.
  always_comb begin
    coef_sel = coef_q[bqdf1_pkg::REG_FF_GAIN_0];
    oper_sel = OPER_W'(x_q);
    case (prod_q)
      P_FF0: begin
        coef_sel = coef_q[bqdf1_pkg::REG_FF_GAIN_0];
        oper_sel = OPER_W'(x_q);
      end
      P_FF1: begin
        coef_sel = coef_q[bqdf1_pkg::REG_FF_GAIN_1];
        oper_sel = OPER_W'(prev_input_1_q);
      end
      P_FF2: begin
        coef_sel = coef_q[bqdf1_pkg::REG_FF_GAIN_2];
        oper_sel = OPER_W'(prev_input_2_q);
      end
      P_FB1: begin
        coef_sel = coef_q[bqdf1_pkg::REG_FB_GAIN_1];
        oper_sel = OPER_W'(prev_output_1_q);
      end
      P_FB2: begin
        coef_sel = coef_q[bqdf1_pkg::REG_FB_GAIN_2];
        oper_sel = OPER_W'(prev_output_2_q);
      end
      P_DRY: begin
        coef_sel = coef_q[bqdf1_pkg::REG_DRY_GAIN];
        oper_sel = OPER_W'(x_q);
      end
      P_WET: begin
        coef_sel = coef_q[bqdf1_pkg::REG_WET_GAIN];
        oper_sel = b_q;
      end
      default: begin
        coef_sel = coef_q[bqdf1_pkg::REG_FF_GAIN_0];
        oper_sel = OPER_W'(x_q);
      end
    endcase
  end

  // Sequencer to multiply-accumulate control.
  always_comb begin
    mac_ctrl = '0;
    case (state_q)
      S_IDLE:  mac_ctrl.clear = in_xfer;
      S_LOAD:  mac_ctrl.load  = 1'b1;
      S_MAC: begin
        mac_ctrl.step = 1'b1;
        mac_ctrl.sub  = (prod_q == P_FB1) || (prod_q == P_FB2);
        mac_ctrl.last = last_digit;
      end
      S_RND_B: mac_ctrl.clear = 1'b1;
      default: mac_ctrl = '0;
    endcase
  end

  bqdf1_mac #(
    .COEFF_WIDTH (COEFF_WIDTH),
    .OPER_WIDTH  (OPER_W),
    .ACC_WIDTH   (ACC_W)
  ) u_mac (
    .clk_i  (clk_i),
    .ctrl_i (mac_ctrl),
    .coef_i (coef_sel),
    .oper_i (oper_sel),
    .acc_o  (acc)
  );

  // Both rounding steps add half an LSB and shift arithmetically, so halves
  // round towards positive infinity. Only the final result is saturated.
  always_comb begin
    rnd_sum = acc + RND_HALF;
    rnd_val = rnd_sum >>> COEFF_FRAC_BITS;
    if (rnd_val > SAT_MAX) begin
      sat_val  = SAT_MAX[SAMPLE_WIDTH-1:0];
      sat_clip = 1'b1;
    end else if (rnd_val < SAT_MIN) begin
      sat_val  = SAT_MIN[SAMPLE_WIDTH-1:0];
      sat_clip = 1'b1;
    end else begin
      sat_val  = rnd_val[SAMPLE_WIDTH-1:0];
      sat_clip = 1'b0;
    end
  end

  // Main sequencer. Each product is a load followed by NUM_DIGITS accumulate
  // steps; the biquad sum is rounded between the two groups.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      prod_q          <= P_FF0;
      dig_cnt_q       <= '0;
      x_q             <= '0;
      prev_input_1_q  <= '0;
      prev_input_2_q  <= '0;
      prev_output_1_q <= '0;
      prev_output_2_q <= '0;
      b_q             <= '0;
      out_valid_q     <= 1'b0;
      sample_out_q    <= '0;
      clipped_q       <= 1'b0;
    end else begin
      // In the final rounding state the result register is managed below.
      if (out_valid_q && out_o.ready && (state_q != S_RND_Y)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            x_q     <= in_i.sample_in;
            prod_q  <= P_FF0;
            state_q <= S_LOAD;
          end
        end
        S_LOAD: begin
          dig_cnt_q <= '0;
          state_q   <= S_MAC;
        end
        S_MAC: begin
          if (last_digit) begin
            if (prod_q == P_FB2) begin
              state_q <= S_RND_B;
            end else if (prod_q == P_WET) begin
              state_q <= S_RND_Y;
            end else begin
              prod_q  <= prod_e'(prod_q + 3'd1);
              state_q <= S_LOAD;
            end
          end else begin
            dig_cnt_q <= CNT_W'(dig_cnt_q + 1'b1);
          end
        end
        S_RND_B: begin
          b_q     <= rnd_val[OPER_W-1:0];
          prod_q  <= P_DRY;
          state_q <= S_LOAD;
        end
        S_RND_Y: begin
          // Hold here until the output register is free for the new result.
          if (out_free) begin
            sample_out_q    <= sat_val;
            clipped_q       <= sat_clip;
            out_valid_q     <= 1'b1;
            prev_input_2_q  <= prev_input_1_q;
            prev_input_1_q  <= x_q;
            prev_output_2_q <= prev_output_1_q;
            prev_output_1_q <= sat_val;
            state_q         <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.sample_out = sample_out_q;
  assign out_o.clipped    = clipped_q;

endmodule

### sv/bqdf1_checker.sv
// Port-level checker for the biquad filter, attached to the top level by bind.
`include "assert_macros.svh"

module bqdf1_checker #(
  parameter int SAMPLE_WIDTH = 24
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_i,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input logic [SAMPLE_WIDTH-1:0] sample_out_i,
  input logic                    clipped_i
);

  localparam logic [SAMPLE_WIDTH-1:0] SMAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic [SAMPLE_WIDTH-1:0] SMIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  // A result waiting for the sink keeps its contents.
  `BQ_ASSERT_CLK(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(sample_out_i) && $stable(clipped_i))

  // One sample is in work at a time.
  `BQ_ASSERT_CLK(a_one_in_flight, in_valid_i && in_ready_i |=> !in_ready_i)

  // A saturated result sits on one of the two rails.
  `BQ_ASSERT_CLK(a_clip_rail, out_valid_i && clipped_i |-> sample_out_i == SMAX || sample_out_i == SMIN)

  // A result never appears in the cycle straight after its input transfer.
  `BQ_ASSERT_CLK(a_no_instant_result, in_valid_i && in_ready_i && !out_valid_i |=> !out_valid_i)

endmodule

bind biquad_iir_filter_df1_unit bqdf1_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_bqdf1_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .sample_out_i (out_o.sample_out),
  .clipped_i    (out_o.clipped)
);
